### rtl/aerp_pkg.sv
// shared types and codes for the arm elf relocation patcher
package aerp_pkg;

  localparam int TypeW   = 8;
  localparam int StatusW = 2;
  localparam int WordW   = 32;
  localparam int OffW    = 34;   // branch sum, wide enough to hold it without wrap
  localparam int EncW    = 25;   // thumb bl/b.w offset field

  // relocation type numbers
  localparam logic [TypeW-1:0] T_NONE       = 8'd0;
  localparam logic [TypeW-1:0] T_ABS32      = 8'd2;
  localparam logic [TypeW-1:0] T_REL32      = 8'd3;
  localparam logic [TypeW-1:0] T_THM_CALL   = 8'd10;
  localparam logic [TypeW-1:0] T_RELATIVE   = 8'd23;
  localparam logic [TypeW-1:0] T_THM_JUMP24 = 8'd30;
  localparam logic [TypeW-1:0] T_TARGET1    = 8'd38;
  localparam logic [TypeW-1:0] T_PREL31     = 8'd42;
  localparam logic [TypeW-1:0] T_MOVW       = 8'd47;
  localparam logic [TypeW-1:0] T_MOVT       = 8'd48;

  // status codes
  localparam logic [StatusW-1:0] ST_OK    = 2'd0;
  localparam logic [StatusW-1:0] ST_BAD   = 2'd1;
  localparam logic [StatusW-1:0] ST_UNSUP = 2'd2;

  // operation class decoded from the type number
  typedef enum logic [2:0] {
    OP_KEEP,
    OP_ABS,
    OP_REL,
    OP_PREL31,
    OP_BRANCH,
    OP_MOVW,
    OP_MOVT,
    OP_UNSUP
  } op_t;

endpackage

### rtl/arm_elf_relocation_patcher.sv
// arm elf relocation patcher: three-stage pipeline with a registered output
// items pass the stage 1, stage 2 and output registers on to the master side
// throughput: one item per cycle; s_tready is low only while the output
// register holds an item that the sink does not take, which halts all stages
// reset: rst clears the valid bit of every stage, so no item survives reset
// the stages hold no state across items, so no clearing pass is needed
module arm_elf_relocation_patcher (
  input  logic                          clk,
  input  logic                          rst,
  // input item
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [3*aerp_pkg::WordW-1:0]  s_tdata,  // sym_value, place_addr, old_word
  input  logic [aerp_pkg::TypeW+1:0]    s_tuser,  // reloc_type, sym_present, sym_is_func
  // result item
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [aerp_pkg::WordW-1:0]    m_tdata,  // new_word
  output logic [aerp_pkg::StatusW-1:0]  m_tuser   // status
);
  import aerp_pkg::*;

  // the whole pipe moves when the output register is free or drained
  logic advance;
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;

  // input field split
  logic [TypeW-1:0] in_type;
  logic             in_present;
  logic             in_func;
  logic [WordW-1:0] in_sym;
  logic [WordW-1:0] in_place;
  logic [WordW-1:0] in_word;

  assign in_sym     = s_tdata[WordW-1:0];
  assign in_place   = s_tdata[2*WordW-1:WordW];
  assign in_word    = s_tdata[3*WordW-1:2*WordW];
  assign in_type    = s_tuser[TypeW-1:0];
  assign in_present = s_tuser[TypeW];
  assign in_func    = s_tuser[TypeW+1];

  // ---------------------------------------------------------------
  // stage 1: symbol value, s - p, type decode, branch field decode
  // ---------------------------------------------------------------
  logic             func_c;
  logic [WordW-1:0] s_c;
  op_t              op_c;
  logic [EncW-1:0]  enc_c;

  assign func_c = in_present && in_func;
  // symbol value is zero without a symbol, thumb bit forced for functions
  assign s_c    = (in_present ? in_sym : '0) | {{(WordW-1){1'b0}}, func_c};

  always_comb begin
    case (in_type) inside
      T_NONE, T_RELATIVE:         op_c = OP_KEEP;
      T_ABS32, T_TARGET1:         op_c = OP_ABS;
      T_REL32:                    op_c = OP_REL;
      T_PREL31:                   op_c = OP_PREL31;
      T_THM_CALL, T_THM_JUMP24:   op_c = OP_BRANCH;
      T_MOVW:                     op_c = OP_MOVW;
      T_MOVT:                     op_c = OP_MOVT;
      default:                    op_c = OP_UNSUP;
    endcase
  end

  // first halfword in the low bits, second in the high bits
  // enc = s : ~(j1^s) : ~(j2^s) : imm10 : imm11 : 0
  assign enc_c = {in_word[10],
                  ~(in_word[29] ^ in_word[10]),
                  ~(in_word[27] ^ in_word[10]),
                  in_word[9:0],
                  in_word[26:16],
                  1'b0};

  logic             v1;
  op_t              op1;
  logic             func1;
  logic [WordW-1:0] s1;
  logic [WordW-1:0] sp1;
  logic [WordW-1:0] w1;
  logic [EncW-1:0]  enc1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (advance) begin
      v1 <= s_tvalid;
    end
    if (advance) begin
      op1   <= op_c;
      func1 <= func_c;
      s1    <= s_c;
      sp1   <= s_c - in_place;
      w1    <= in_word;
      enc1  <= enc_c;
    end
  end

  // ---------------------------------------------------------------
  // stage 2: the adds (data words, branch offset, mov immediate)
  // ---------------------------------------------------------------
  logic [WordW-1:0] sum_abs;
  logic [WordW-1:0] sum_rel;
  logic [WordW-1:0] calc_c;
  logic [OffW-1:0]  off_c;
  logic [15:0]      mov_imm;
  logic [15:0]      imm_c;

  assign sum_abs = w1 + s1;
  assign sum_rel = w1 + sp1;
  // exact signed sum of the decoded offset and s - p
  assign off_c   = {{(OffW-EncW){enc1[EncW-1]}}, enc1} +
                   {{(OffW-WordW){sp1[WordW-1]}}, sp1};
  // mov immediate: imm4 : i : imm3 : imm8 spread over the two halfwords
  assign mov_imm = {w1[3:0], w1[10], w1[30:28], w1[23:16]};
  // movt adds the upper half of s, movw the lower half
  assign imm_c   = mov_imm + ((op1 == OP_MOVT) ? s1[31:16] : s1[15:0]);

  always_comb begin
    case (op1)
      OP_ABS:    calc_c = sum_abs;
      OP_REL:    calc_c = sum_rel;
      OP_PREL31: calc_c = {w1[31], sum_rel[30:0]};
      default:   calc_c = w1;
    endcase
  end

  logic             v2;
  op_t              op2;
  logic             func2;
  logic [WordW-1:0] w2;
  logic [WordW-1:0] calc2;
  logic [OffW-1:0]  off2;
  logic [15:0]      imm2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (advance) begin
      v2 <= v1;
    end
    if (advance) begin
      op2   <= op1;
      func2 <= func1;
      w2    <= w1;
      calc2 <= calc_c;
      off2  <= off_c;
      imm2  <= imm_c;
    end
  end

  // ---------------------------------------------------------------
  // stage 3: branch checks, re-encoding, result select
  // ---------------------------------------------------------------
  logic             br_range_bad;
  logic             br_thumb_bad;
  logic [WordW-1:0] br_word;
  logic [WordW-1:0] mov_word;
  logic [WordW-1:0] word_c;
  logic [StatusW-1:0] status_c;

  // in range when bits above 24 all copy the sign bit
  assign br_range_bad = !((&off2[OffW-1:EncW-1]) || !(|off2[OffW-1:EncW-1]));
  // a call into thumb code must land on an odd target
  assign br_thumb_bad = func2 && !off2[0];

  // opcode bits kept, offset bit 0 dropped
  assign br_word = {w2[31:30],
                    off2[24] ^ ~off2[23],
                    w2[28],
                    off2[24] ^ ~off2[22],
                    off2[11:1],
                    w2[15:11],
                    off2[24],
                    off2[21:12]};

  assign mov_word = {w2[31], imm2[10:8], w2[27:24], imm2[7:0],
                     w2[15:11], imm2[11], w2[9:4], imm2[15:12]};

  always_comb begin
    word_c   = w2;
    status_c = ST_OK;
    case (op2)
      OP_KEEP:   word_c = w2;
      OP_ABS, OP_REL, OP_PREL31: word_c = calc2;
      OP_BRANCH: begin
        if (br_range_bad || br_thumb_bad) begin
          status_c = ST_BAD;
        end else begin
          word_c = br_word;
        end
      end
      OP_MOVW, OP_MOVT: word_c = mov_word;
      OP_UNSUP:  status_c = ST_UNSUP;
      default:   status_c = ST_UNSUP;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= v2;
    end
    if (advance) begin
      m_tdata <= word_c;
      m_tuser <= status_c;
    end
  end

  // ---------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------

  // status is always one of the three defined codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_BAD || m_tuser == ST_UNSUP))
    else $error("undefined status code on result");

  // an unsupported type leaves the word untouched
  a_unsup_keeps_word: assert property (@(posedge clk) disable iff (rst)
    (advance && v2 && op2 == OP_UNSUP) |=> (m_tuser == ST_UNSUP && m_tdata == $past(w2)))
    else $error("unsupported type changed the word");

  // a rejected branch returns the original word
  a_bad_keeps_word: assert property (@(posedge clk) disable iff (rst)
    (advance && v2 && op2 == OP_BRANCH && status_c == ST_BAD)
      |=> (m_tuser == ST_BAD && m_tdata == $past(w2)))
    else $error("rejected branch did not return old word");

  // an empty output register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

endmodule
